/* design/mqd_pkg.sv */
// Shared types, codes and probability state tables of the MQ decoder.
`default_nettype none
package mqd_pkg;

  localparam int SEG_BYTES_DEF = 4096;
  localparam int NUM_CTX       = 19;
  localparam int NUM_STATES    = 47;

  // input word kind codes
  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_START  = 3'd1;
  localparam logic [2:0] KIND_RESET  = 3'd2;
  localparam logic [2:0] KIND_DECODE = 3'd3;
  localparam logic [2:0] KIND_RAW    = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_RESET_CTX,
    OP_DECODE,
    OP_RAW
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  byte_value;
    logic [11:0] byte_addr;
    logic [11:0] seg_start;
    logic [12:0] seg_length;
    logic        bypass;
    logic [4:0]  context_req;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PRIME1_W,
    BK_PRIME1,
    BK_PRIME2_W,
    BK_PRIME2,
    BK_DEC,
    BK_RENORM,
    BK_REN_W,
    BK_REN_LD,
    BK_RAW_W,
    BK_RAW_LD
  } bk_state_t;

  localparam logic [5:0] NMPS_TAB [0:NUM_STATES-1] = '{
    6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd38, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12,
    6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
    6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46};

  localparam logic [5:0] NLPS_TAB [0:NUM_STATES-1] = '{
    6'd1, 6'd6, 6'd9, 6'd12, 6'd29, 6'd33, 6'd6, 6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
    6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
    6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46};

  localparam logic [15:0] QE_TAB [0:NUM_STATES-1] = '{
    16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
    16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
    16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
    16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
    16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
    16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};

  // sense flips only on the LPS path of states 0, 6 and 14
  function automatic logic flip_of(input logic [5:0] st);
    return (st == 6'd0) || (st == 6'd6) || (st == 6'd14);
  endfunction

  function automatic logic [5:0] ctx_reset_idx(input int i);
    logic [5:0] v;
    v = 6'd0;
    if (i == 0) v = 6'd4;
    if (i == 17) v = 6'd3;
    if (i == 18) v = 6'd46;
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/mqd_in_if.sv */
// Input channel: valid/ready handshake with the decoder command word.
`default_nettype none
interface mqd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic [11:0] byte_addr;
  logic [11:0] seg_start;
  logic [12:0] seg_length;
  logic        bypass;
  logic [4:0]  context_req;

  modport source(output valid, kind, byte_value, byte_addr, seg_start, seg_length,
                 bypass, context_req, input ready);
  modport sink(input valid, kind, byte_value, byte_addr, seg_start, seg_length,
               bypass, context_req, output ready);
endinterface
`default_nettype wire

/* design/mqd_out_if.sv */
// Result channel: valid/ready handshake with the decoded symbol.
`default_nettype none
interface mqd_out_if;
  logic valid;
  logic ready;
  logic symbol;
  logic symbol_valid;

  modport source(output valid, symbol, symbol_valid, input ready);
  modport sink(input valid, symbol, symbol_valid, output ready);
endinterface
`default_nettype wire

/* design/mq_arithmetic_decoder_unit.sv */
// Store, context reset, bypass start and a raw bit from the held byte finish in BK_IDLE.
// A raw bit that fetches passes BK_RAW_W, BK_RAW_LD; an MQ start passes the BK_PRIME states.
// Decode: BK_DEC, then BK_RENORM; byte fetches go via BK_REN_W, BK_REN_LD (buffer read port).
// One item is executed at a time; a 2-entry queue keeps accepting while the back end works.
// Synchronous active-low reset restores the context start states and clears the coder
// registers; the segment buffer is not cleared and holds garbage until written.
`default_nettype none
module mq_arithmetic_decoder_unit import mqd_pkg::*; #(
  parameter int SEG_BYTES = SEG_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mqd_in_if.sink     in_ch,
  mqd_out_if.source  out_ch
);
  qhead_t head;
  logic   pop;

  mqd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  mqd_back #(.SEG_BYTES(SEG_BYTES)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule
`default_nettype wire

/* design/mqd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/mqd_front.sv */
// Front end: accepts command words, classifies them and queues them for the back end.
`default_nettype none
module mqd_front import mqd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mqd_in_if.sink    in_ch,
  output qhead_t    head,
  input  wire logic pop
);
  item_t      q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.byte_value  = in_ch.byte_value;
    cls.byte_addr   = in_ch.byte_addr;
    cls.seg_start   = in_ch.seg_start;
    cls.seg_length  = in_ch.seg_length;
    cls.bypass      = in_ch.bypass;
    cls.context_req = in_ch.context_req;
    case (in_ch.kind)
      KIND_LOAD:   cls.op = OP_LOAD;
      KIND_START:  cls.op = OP_START;
      KIND_RESET:  cls.op = OP_RESET_CTX;
      KIND_DECODE: cls.op = OP_DECODE;
      KIND_RAW:    cls.op = OP_RAW;
      default:     cls.op = OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != 2'd0);
  assign head.item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule
`default_nettype wire

/* design/mqd_back.sv */
// Back end: segment buffer, byte fetch, MQ decode with renormalization and raw bits.
`default_nettype none
module mqd_back import mqd_pkg::*; #(
  parameter int SEG_BYTES = SEG_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qhead_t head,
  output logic        pop,
  mqd_out_if.source   out_ch
);
  localparam int AW = $clog2(SEG_BYTES);
  localparam int PW = ($clog2(SEG_BYTES + 1) > 13) ? $clog2(SEG_BYTES + 1) : 13;

  bk_state_t      st_r, st_nxt;
  logic [15:0]    a_r, a_nxt;
  logic [23:0]    c_r, c_nxt;
  logic [3:0]     bl_r, bl_nxt;
  logic [7:0]     last_r, last_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [PW-1:0]  ep_r, ep_nxt;
  logic [5:0]     cidx_r [NUM_CTX];
  logic [5:0]     cidx_nxt [NUM_CTX];
  logic           csns_r [NUM_CTX];
  logic           csns_nxt [NUM_CTX];
  logic [4:0]     lab_r, lab_nxt;
  logic [15:0]    p_r, p_nxt;
  logic [5:0]     cst_r, cst_nxt;
  logic           sym_r, sym_nxt;
  logic [4:0]     sh_r, sh_nxt;
  logic           ov_r, ov_nxt;
  logic           osym_r, osym_nxt;
  logic           osv_r, osv_nxt;

  logic           we;
  logic [7:0]     rdata;
  logic           slot_free;
  item_t          it;

  // byte fetch results
  logic           ld_exh;
  logic [3:0]     ld_bl;
  logic [7:0]     ld_last;
  logic [PW-1:0]  ld_rp;
  logic [23:0]    ld_c;
  logic           raw_exh;
  logic [3:0]     raw_bl;
  logic [7:0]     raw_last;

  // decode step
  logic [5:0]     st_sel;
  logic [15:0]    a_sub;
  logic [15:0]    hi;
  logic           mps;
  logic           dsym;
  logic [15:0]    a_dec;
  logic [PW:0]    stop;

  assign it = head.item;

  mqd_ram #(.WIDTH(8), .DEPTH(SEG_BYTES)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(it.byte_addr)),
    .wdata (it.byte_value),
    .raddr (AW'(rp_r)),
    .rdata (rdata)
  );

  assign slot_free       = !ov_r || out_ch.ready;
  assign out_ch.valid        = ov_r;
  assign out_ch.symbol       = osym_r;
  assign out_ch.symbol_valid = osv_r;

  always_comb begin
    ld_exh  = (rp_r >= ep_r) || (last_r == 8'hFF && rdata > 8'h8F);
    ld_bl   = ld_exh ? 4'd8 : ((last_r == 8'hFF) ? 4'd7 : 4'd8);
    ld_last = ld_exh ? last_r : rdata;
    ld_rp   = ld_exh ? rp_r : rp_r + PW'(1);
    if (ld_exh) begin
      ld_c = c_r + 24'h0000FF;
    end else if (last_r == 8'hFF) begin
      ld_c = c_r + {15'd0, rdata, 1'b0};
    end else begin
      ld_c = c_r + {16'd0, rdata};
    end
    raw_exh  = (rp_r >= ep_r);
    raw_bl   = raw_exh ? 4'd8 : ((last_r == 8'hFF) ? 4'd7 : 4'd8);
    raw_last = raw_exh ? 8'hFF : rdata;
  end

  always_comb begin
    st_sel = cidx_r[it.context_req];
    if (st_sel > 6'(NUM_STATES - 1)) st_sel = 6'(NUM_STATES - 1);
    a_sub = a_r - p_r;
    mps   = csns_r[lab_r] ^ (a_sub < p_r);
    hi    = c_r[23:8];
    if (hi < p_r) begin
      dsym  = ~mps;
      a_dec = p_r;
    end else begin
      dsym  = mps;
      a_dec = a_sub;
    end
    stop = (PW + 1)'(it.seg_start) + (PW + 1)'(it.seg_length);
  end

  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    c_nxt    = c_r;
    bl_nxt   = bl_r;
    last_nxt = last_r;
    rp_nxt   = rp_r;
    ep_nxt   = ep_r;
    cidx_nxt = cidx_r;
    csns_nxt = csns_r;
    lab_nxt  = lab_r;
    p_nxt    = p_r;
    cst_nxt  = cst_r;
    sym_nxt  = sym_r;
    sh_nxt   = sh_r;
    ov_nxt   = ov_r && !out_ch.ready;
    osym_nxt = osym_r;
    osv_nxt  = osv_r;
    pop      = 1'b0;
    we       = 1'b0;

    case (st_r)
      BK_IDLE: begin
        if (head.valid && slot_free) begin
          pop      = 1'b1;
          ov_nxt   = 1'b1;
          osym_nxt = 1'b0;
          osv_nxt  = 1'b0;
          case (it.op)
            OP_LOAD: begin
              we = (32'(it.byte_addr) < SEG_BYTES);
            end
            OP_START: begin
              rp_nxt   = PW'(it.seg_start);
              ep_nxt   = (stop > (PW + 1)'(SEG_BYTES)) ? PW'(SEG_BYTES) : PW'(stop);
              last_nxt = 8'd0;
              if (it.bypass) begin
                bl_nxt = 4'd0;
              end else begin
                // result waits for the two priming fetches
                ov_nxt = 1'b0;
                a_nxt  = 16'h8000;
                c_nxt  = 24'd0;
                st_nxt = BK_PRIME1_W;
              end
            end
            OP_RESET_CTX: begin
              for (int i = 0; i < NUM_CTX; i++) begin
                cidx_nxt[i] = ctx_reset_idx(i);
                csns_nxt[i] = 1'b0;
              end
            end
            OP_DECODE: begin
              osv_nxt = 1'b1;
              if (32'(it.context_req) < NUM_CTX) begin
                ov_nxt  = 1'b0;
                lab_nxt = it.context_req;
                cst_nxt = st_sel;
                p_nxt   = QE_TAB[st_sel];
                st_nxt  = BK_DEC;
              end
            end
            OP_RAW: begin
              osv_nxt = 1'b1;
              if (bl_r != 4'd0) begin
                bl_nxt   = bl_r - 4'd1;
                osym_nxt = last_r[3'(bl_r - 4'd1)];
              end else begin
                ov_nxt = 1'b0;
                st_nxt = BK_RAW_W;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_PRIME1_W: st_nxt = BK_PRIME1;
      BK_PRIME1: begin
        c_nxt    = ld_c << ld_bl;
        bl_nxt   = ld_bl;
        last_nxt = ld_last;
        rp_nxt   = ld_rp;
        st_nxt   = BK_PRIME2_W;
      end
      BK_PRIME2_W: st_nxt = BK_PRIME2;
      BK_PRIME2: begin
        c_nxt    = ld_c << 7;
        bl_nxt   = ld_bl - 4'd7;
        last_nxt = ld_last;
        rp_nxt   = ld_rp;
        ov_nxt   = 1'b1;
        osym_nxt = 1'b0;
        osv_nxt  = 1'b0;
        st_nxt   = BK_IDLE;
      end
      BK_DEC: begin
        a_nxt = a_dec;
        if (hi >= p_r) begin
          c_nxt = {hi - p_r, c_r[7:0]};
        end
        // adapt the context only when a renormalization follows
        if (!a_dec[15]) begin
          if (dsym == csns_r[lab_r]) begin
            cidx_nxt[lab_r] = NMPS_TAB[cst_r];
          end else begin
            csns_nxt[lab_r] = csns_r[lab_r] ^ flip_of(cst_r);
            cidx_nxt[lab_r] = NLPS_TAB[cst_r];
          end
        end
        sym_nxt = dsym;
        sh_nxt  = 5'd0;
        st_nxt  = BK_RENORM;
      end
      BK_RENORM: begin
        if (!a_r[15] && sh_r < 5'd16) begin
          if (bl_r == 4'd0) begin
            st_nxt = BK_REN_W;
          end else begin
            a_nxt  = a_r << 1;
            c_nxt  = c_r << 1;
            bl_nxt = bl_r - 4'd1;
            sh_nxt = sh_r + 5'd1;
          end
        end else begin
          ov_nxt   = 1'b1;
          osym_nxt = sym_r;
          osv_nxt  = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      BK_REN_W: st_nxt = BK_REN_LD;
      BK_REN_LD: begin
        a_nxt    = a_r << 1;
        c_nxt    = ld_c << 1;
        bl_nxt   = ld_bl - 4'd1;
        last_nxt = ld_last;
        rp_nxt   = ld_rp;
        sh_nxt   = sh_r + 5'd1;
        st_nxt   = BK_RENORM;
      end
      BK_RAW_W: st_nxt = BK_RAW_LD;
      BK_RAW_LD: begin
        bl_nxt   = raw_bl - 4'd1;
        last_nxt = raw_last;
        rp_nxt   = raw_exh ? rp_r : rp_r + PW'(1);
        ov_nxt   = 1'b1;
        osym_nxt = raw_last[3'(raw_bl - 4'd1)];
        osv_nxt  = 1'b1;
        st_nxt   = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      a_r    <= 16'd0;
      c_r    <= 24'd0;
      bl_r   <= 4'd0;
      last_r <= 8'd0;
      rp_r   <= '0;
      ep_r   <= '0;
      ov_r   <= 1'b0;
      for (int i = 0; i < NUM_CTX; i++) begin
        cidx_r[i] <= ctx_reset_idx(i);
        csns_r[i] <= 1'b0;
      end
    end else begin
      st_r   <= st_nxt;
      a_r    <= a_nxt;
      c_r    <= c_nxt;
      bl_r   <= bl_nxt;
      last_r <= last_nxt;
      rp_r   <= rp_nxt;
      ep_r   <= ep_nxt;
      ov_r   <= ov_nxt;
      cidx_r <= cidx_nxt;
      csns_r <= csns_nxt;
    end
    lab_r  <= lab_nxt;
    p_r    <= p_nxt;
    cst_r  <= cst_nxt;
    sym_r  <= sym_nxt;
    sh_r   <= sh_nxt;
    osym_r <= osym_nxt;
    osv_r  <= osv_nxt;
  end
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the MQ arithmetic decoder unit with its own decoder model.
`default_nettype none
module tb_top import mqd_pkg::*; ;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int         BUF_BYTES     = SEG_BYTES_DEF;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  bval;
    logic [11:0] baddr;
    logic [11:0] sstart;
    logic [12:0] slen;
    logic        byp;
    logic [4:0]  ctx;
  } cmd_t;

  typedef struct packed {
    logic symbol;
    logic symbol_valid;
  } sym_res_t;

  class mq_scoreboard;
    logic [5:0]  ctx_state[NUM_CTX];
    logic        ctx_mps[NUM_CTX];
    logic [15:0] a_reg;
    logic [23:0] c_reg;
    int          ct;
    logic [7:0]  prev_byte;
    int          rpos;
    int          epos;
    logic [7:0]  seg_mem[BUF_BYTES];
    sym_res_t    pending[$];

    function void clear_contexts();
      for (int i = 0; i < NUM_CTX; i++) begin
        ctx_state[i] = 6'd0;
        ctx_mps[i] = 1'b0;
      end
      ctx_state[0] = 6'd4;
      ctx_state[17] = 6'd3;
      ctx_state[18] = 6'd46;
    endfunction

    function void reset_all();
      clear_contexts();
      a_reg = '0;
      c_reg = '0;
      ct = 0;
      prev_byte = '0;
      rpos = 0;
      epos = 0;
    endfunction

    // feed 1s past the end or at a marker
    function void fetch_byte();
      ct = 8;
      if (rpos >= epos || (prev_byte == 8'hFF && seg_mem[rpos] > 8'h8F)) begin
        c_reg = c_reg + 24'hFF;
      end else begin
        if (prev_byte == 8'hFF) ct = 7;
        prev_byte = seg_mem[rpos];
        rpos++;
        c_reg = c_reg + (24'(prev_byte) << (8 - ct));
      end
    endfunction

    function void begin_segment(int s, int l, logic raw);
      int stop;
      stop = s + l;
      if (stop > BUF_BYTES) stop = BUF_BYTES;
      rpos = s;
      epos = stop;
      prev_byte = '0;
      if (raw) begin
        ct = 0;
      end else begin
        a_reg = 16'h8000;
        c_reg = '0;
        fetch_byte();
        c_reg = c_reg << ct;
        fetch_byte();
        c_reg = c_reg << 7;
        ct = ct - 7;
      end
    endfunction

    function logic decode_bit(logic [4:0] label);
      logic [5:0]  st;
      logic [15:0] qe;
      logic [15:0] hi;
      logic        mps;
      logic        sym;
      logic        flip;
      int          shifts;
      if (label >= NUM_CTX) return 1'b0;
      st = ctx_state[label];
      if (st >= NUM_STATES) st = 6'(NUM_STATES - 1);
      qe = QE_TAB[st];
      mps = ctx_mps[label];
      a_reg = a_reg - qe;
      if (a_reg < qe) mps = ~mps;
      hi = c_reg[23:8];
      if (hi < qe) begin
        sym = ~mps;
        a_reg = qe;
      end else begin
        sym = mps;
        c_reg[23:8] = hi - qe;
      end
      if (a_reg < 16'h8000) begin
        if (sym == ctx_mps[label]) begin
          ctx_state[label] = NMPS_TAB[st];
        end else begin
          flip = (st == 6'd0) || (st == 6'd6) || (st == 6'd14);
          ctx_mps[label] = ctx_mps[label] ^ flip;
          ctx_state[label] = NLPS_TAB[st];
        end
      end
      shifts = 0;
      while (a_reg < 16'h8000 && shifts < 16) begin
        if (ct == 0) fetch_byte();
        a_reg = a_reg << 1;
        c_reg = c_reg << 1;
        ct--;
        shifts++;
      end
      return sym;
    endfunction

    function logic next_raw_bit();
      if (ct == 0) begin
        ct = 8;
        if (rpos >= epos) begin
          prev_byte = 8'hFF;
        end else begin
          if (prev_byte == 8'hFF) ct = 7;
          prev_byte = seg_mem[rpos];
          rpos++;
        end
      end
      ct--;
      return prev_byte[ct];
    endfunction

    function void note_word(cmd_t w);
      sym_res_t r;
      r = '0;
      case (w.kind)
        KIND_LOAD:   seg_mem[w.baddr] = w.bval;
        KIND_START:  begin_segment(int'(w.sstart), int'(w.slen), w.byp);
        KIND_RESET:  clear_contexts();
        KIND_DECODE: begin
          r.symbol = decode_bit(w.ctx);
          r.symbol_valid = 1'b1;
        end
        KIND_RAW: begin
          r.symbol = next_raw_bit();
          r.symbol_valid = 1'b1;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function bit check_word(sym_res_t got, output string msg);
      sym_res_t exp_r;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result word sym=%0d vld=%0d",
                        got.symbol, got.symbol_valid);
        return 1'b0;
      end
      exp_r = pending.pop_front();
      if (got.symbol !== exp_r.symbol) begin
        msg = $sformatf("symbol %0d, want %0d", got.symbol, exp_r.symbol);
        return 1'b0;
      end
      if (got.symbol_valid !== exp_r.symbol_valid) begin
        msg = $sformatf("symbol_valid %0d, want %0d", got.symbol_valid, exp_r.symbol_valid);
        return 1'b0;
      end
      msg = "";
      return 1'b1;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mqd_in_if  in_ch();
  mqd_out_if out_ch();

  mq_arithmetic_decoder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mq_scoreboard sb;
  int           errors;
  int           words_sent;
  int           send_idle;
  int           recv_idle;
  logic         rx_hold;
  bit           written[BUF_BYTES];
  event         hold_ev;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // long receiver stall, counted here
  initial begin
    rx_hold <= 1'b0;
    forever begin
      @(hold_ev);
      @(posedge clk);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    sym_res_t got;
    string    msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.symbol = out_ch.symbol;
      got.symbol_valid = out_ch.symbol_valid;
      if (!sb.check_word(got, msg)) report(msg);
    end
  end

  function automatic cmd_t blank_cmd(logic [2:0] k);
    cmd_t w;
    w.kind = k;
    w.bval = 8'($urandom);
    w.baddr = 12'($urandom);
    w.sstart = 12'($urandom);
    w.slen = 13'($urandom);
    w.byp = 1'($urandom);
    w.ctx = 5'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'hFF;
      1: return 8'h80 + 8'($urandom_range(127));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(input cmd_t w);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= w.kind;
    in_ch.byte_value <= w.bval;
    in_ch.byte_addr <= w.baddr;
    in_ch.seg_start <= w.sstart;
    in_ch.seg_length <= w.slen;
    in_ch.bypass <= w.byp;
    in_ch.context_req <= w.ctx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    if (w.kind <= KIND_RAW) words_sent++;
  endtask

  task automatic store_byte(input int addr, input logic [7:0] v);
    cmd_t w;
    w = blank_cmd(KIND_LOAD);
    w.baddr = 12'(addr);
    w.bval = v;
    written[addr] = 1'b1;
    send_word(w);
  endtask

  task automatic open_segment(input int s, input int l, input logic raw);
    cmd_t w;
    w = blank_cmd(KIND_START);
    w.sstart = 12'(s);
    w.slen = 13'(l);
    w.byp = raw;
    send_word(w);
  endtask

  task automatic send_op(input logic [2:0] k, input logic [4:0] label);
    cmd_t w;
    w = blank_cmd(k);
    w.ctx = label;
    send_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // load a segment, maybe send a spare word or a context reset, start it, then pull symbols out of it
  task automatic run_segment();
    int   s;
    int   l;
    int   stop;
    int   n;
    logic raw;
    if ($urandom_range(19) == 0) begin
      s = $urandom_range(4064, 4095);
      l = $urandom_range(1) ? 4096 : $urandom_range(BUF_BYTES - s, 4096);
      for (int a = s; a < BUF_BYTES; a++)
        if (!written[a]) store_byte(a, pick_byte());
    end else begin
      s = $urandom_range(0, 4095);
      l = $urandom_range(0, 12);
      stop = (s + l > BUF_BYTES) ? BUF_BYTES : s + l;
      for (int a = s; a < stop; a++) store_byte(a, pick_byte());
    end
    if ($urandom_range(9) == 0)
      send_op(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 5'd0);
    if ($urandom_range(3) == 0) send_op(KIND_RESET, 5'd0);
    raw = ($urandom_range(3) == 0);
    open_segment(s, l, raw);
    n = $urandom_range(4, 40);
    for (int i = 0; i < n; i++) begin
      if (($urandom_range(9) < 8) ^ raw)
        send_op(KIND_DECODE, ($urandom_range(9) == 0) ? 5'($urandom_range(19, 31))
                                                      : 5'($urandom_range(0, 18)));
      else
        send_op(KIND_RAW, 5'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    errors = 0;
    words_sent = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_LOAD;
    in_ch.byte_value <= '0;
    in_ch.byte_addr <= '0;
    in_ch.seg_start <= '0;
    in_ch.seg_length <= '0;
    in_ch.bypass <= 1'b0;
    in_ch.context_req <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decode and raw bit with no segment started, label out of range, spare kinds
    send_op(KIND_DECODE, 5'd0);
    send_op(KIND_RAW, 5'd0);
    send_op(KIND_DECODE, 5'd31);
    send_op(KIND_SPARE_LO, 5'd0);
    send_op(KIND_SPARE_HI, 5'd0);
    // stuffed byte followed by a marker, then ordinary stuffing
    store_byte(0, 8'hFF);
    store_byte(1, 8'h90);
    store_byte(2, 8'h00);
    store_byte(3, 8'hFF);
    store_byte(4, 8'h7F);
    open_segment(0, 5, 1'b0);
    send_op(KIND_DECODE, 5'd0);
    send_op(KIND_DECODE, 5'd17);
    send_op(KIND_DECODE, 5'd18);
    send_op(KIND_DECODE, 5'd5);
    open_segment(3, 2, 1'b1);
    for (int i = 0; i < 4; i++) send_op(KIND_RAW, 5'd0);
    // segment end clamped to the buffer size
    store_byte(4095, 8'hFF);
    open_segment(4095, 4096, 1'b0);
    send_op(KIND_DECODE, 5'd1);
    open_segment(2, 0, 1'b0);
    send_op(KIND_DECODE, 5'd2);
    send_op(KIND_RESET, 5'd0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 62 : 0;
      recv_idle = (ph == 0) ? 62 : (ph == 1) ? 18 : 0;
      if (ph != 1) -> hold_ev;
      while (words_sent < 400 * (ph + 1)) run_segment();
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
